[rtl/core/cnfsa_pkg.sv]
// Shared types and constants of the circular next-free-slot allocator.
`default_nettype none

package cnfsa_pkg;

  // Width of slot numbers, the slot count register and the request field.
  localparam int CNT_W = 11;
  // The occupancy bitmap is held as words of this many bits.
  localparam int WORD_W = 32;
  localparam int BIT_W = $clog2(WORD_W);
  localparam int NUM_SLOTS_DEF = 1024;
  localparam logic [CNT_W-1:0] SLOTS_RST = CNT_W'(1024);

  typedef enum logic [1:0] {
    STAT_EXACT = 2'd0,
    STAT_OTHER = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_BAD   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN
  } state_t;

  // Result of searching one bitmap word for a free slot.
  typedef struct packed {
    logic             found;
    logic [BIT_W-1:0] bit_idx;
  } hit_t;

endpackage

`default_nettype wire

[rtl/core/cnfsa_find.sv]
// Windowed search for the lowest free slot in one bitmap word.
`default_nettype none

module cnfsa_find
  import cnfsa_pkg::*;
#(
  parameter int ADDR_W = 5
) (
  input  wire logic [WORD_W-1:0] word,
  input  wire logic [ADDR_W-1:0] addr,
  input  wire logic [CNT_W-1:0]  lo,
  input  wire logic [CNT_W-1:0]  hi,
  output hit_t                   hit
);

  localparam int WI_W = (ADDR_W > CNT_W - BIT_W) ? ADDR_W : CNT_W - BIT_W;

  logic [WI_W-1:0]   addr_x;
  logic [WI_W-1:0]   lo_word;
  logic [WI_W-1:0]   hi_word;
  logic [WORD_W-1:0] lo_mask;
  logic [WORD_W-1:0] hi_mask;
  logic [WORD_W-1:0] cand;

  assign addr_x  = WI_W'(addr);
  assign lo_word = WI_W'(lo[CNT_W-1:BIT_W]);
  assign hi_word = WI_W'(hi[CNT_W-1:BIT_W]);

  // Slot indices g of this word qualify when lo <= g < hi.
  always_comb begin
    if (addr_x > lo_word) begin
      lo_mask = '1;
    end else if (addr_x == lo_word) begin
      lo_mask = {WORD_W{1'b1}} << lo[BIT_W-1:0];
    end else begin
      lo_mask = '0;
    end
    if (addr_x < hi_word) begin
      hi_mask = '1;
    end else if (addr_x == hi_word) begin
      hi_mask = ~({WORD_W{1'b1}} << hi[BIT_W-1:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand = ~word & lo_mask & hi_mask;

  always_comb begin
    hit.found   = |cand;
    hit.bit_idx = '0;
    for (int j = WORD_W - 1; j >= 0; j--) begin
      if (cand[j]) begin
        hit.bit_idx = BIT_W'(j);
      end
    end
  end

endmodule

`default_nettype wire

[rtl/core/circular_next_free_slot_allocator.sv]
// Top level of the circular next-free-slot allocator: sequencer, bitmap memory, results.
//
//   channel  ports                                      transfer when
//   input    start, busy, in_wanted_slot                start high and busy low
//   result   out_valid, out_granted_slot, out_status    out_valid high (one cycle)
//   config   cfg_we, cfg_wdata                          cfg_we high
//
// A bad request returns its result in the cycle after the transfer, with busy staying low.
// Any other request scans the bitmap one 32-bit word per clock, from the requested
// word to the last active word and then from word 0 back to the requested word, through
// one registered memory read port. At most 33 words are checked for 1024 slots, and busy
// stays high until the result is registered, so no new request is taken during a search.
// The granting write to the bitmap lands at the edge that registers the result.
// After reset the bitmap is cleared one word per cycle with busy high; configuration
// writes are taken throughout. The receiver of results cannot stall.
`default_nettype none

module circular_next_free_slot_allocator
  import cnfsa_pkg::*;
#(
  parameter int NUM_SLOTS = NUM_SLOTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [CNT_W-1:0] in_wanted_slot,
  output logic                  out_valid,
  output logic [CNT_W-1:0]      out_granted_slot,
  output logic [1:0]            out_status,
  input  wire logic             cfg_we,
  input  wire logic [CNT_W-1:0] cfg_wdata
);

  localparam int NUM_WORDS = (NUM_SLOTS + WORD_W - 1) / WORD_W;
  localparam int ADDR_W = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
  localparam logic [ADDR_W-1:0] LAST_WORD = ADDR_W'(NUM_WORDS - 1);

  logic [WORD_W-1:0] mem [NUM_WORDS];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   slots_r;
  logic [ADDR_W-1:0]  clr_addr_r;
  logic [CNT_W-1:0]   w_r;
  logic [CNT_W-1:0]   c_r;
  logic [ADDR_W-1:0]  ws_r;
  logic [ADDR_W-1:0]  last_r;
  logic [ADDR_W-1:0]  rd_addr_r;
  logic               rd_pass_r;
  logic [ADDR_W-1:0]  chk_addr_r;
  logic               chk_pass_r;
  logic               chk_vld_r;
  logic [WORD_W-1:0]  rd_data_r;
  logic               out_valid_r;
  logic [CNT_W-1:0]   out_slot_r;
  status_t            out_status_r;

  logic               accept;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   want_m1;
  logic [CNT_W-1:0]   count_m1;
  logic               bad_req;
  logic [CNT_W-1:0]   win_lo;
  logic [CNT_W-1:0]   win_hi;
  hit_t               hit;
  logic [ADDR_W+BIT_W-1:0] hit_idx;
  logic               chk_last;
  logic               mem_we;
  logic [ADDR_W-1:0]  mem_waddr;
  logic [WORD_W-1:0]  mem_wdata;
  logic               res_grant;
  logic               res_full;

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  // Active slot count saturates at the bitmap size.
  assign count    = (32'(slots_r) > NUM_SLOTS) ? CNT_W'(NUM_SLOTS) : slots_r;
  assign want_m1  = in_wanted_slot - CNT_W'(1);
  assign count_m1 = count - CNT_W'(1);
  assign bad_req  = (in_wanted_slot == '0) || (in_wanted_slot > count);

  // First pass looks at slots from the request up, the wrapped pass at slots below it.
  assign win_lo = chk_pass_r ? '0 : w_r;
  assign win_hi = chk_pass_r ? w_r : c_r;

  cnfsa_find #(
    .ADDR_W(ADDR_W)
  ) u_find (
    .word (rd_data_r),
    .addr (chk_addr_r),
    .lo   (win_lo),
    .hi   (win_hi),
    .hit  (hit)
  );

  assign hit_idx  = {chk_addr_r, hit.bit_idx};
  assign chk_last = chk_pass_r && (chk_addr_r == ws_r);

  always_comb begin
    state_nxt = state_r;
    mem_we    = 1'b0;
    mem_waddr = chk_addr_r;
    mem_wdata = rd_data_r | (WORD_W'(1) << hit.bit_idx);
    res_grant = 1'b0;
    res_full  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_addr_r;
        mem_wdata = '0;
        if (clr_addr_r == LAST_WORD) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept && !bad_req) begin
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chk_vld_r) begin
          if (hit.found) begin
            mem_we    = 1'b1;
            res_grant = 1'b1;
            state_nxt = S_IDLE;
          end else if (chk_last) begin
            res_full  = 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      slots_r     <= SLOTS_RST;
      clr_addr_r  <= '0;
      chk_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        slots_r <= cfg_wdata;
      end
      if (state_r == S_CLEAR) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      chk_vld_r   <= (state_r == S_SCAN) && (state_nxt == S_SCAN);
      out_valid_r <= (accept && bad_req) || res_grant || res_full;
    end
  end

  // Request context, read sequencing and result payload.
  always_ff @(posedge clk) begin
    if (accept) begin
      w_r       <= want_m1;
      c_r       <= count;
      ws_r      <= ADDR_W'(want_m1 >> BIT_W);
      last_r    <= ADDR_W'(count_m1 >> BIT_W);
      rd_addr_r <= ADDR_W'(want_m1 >> BIT_W);
      rd_pass_r <= 1'b0;
    end else if (state_r == S_SCAN) begin
      if (!rd_pass_r && (rd_addr_r == last_r)) begin
        rd_addr_r <= '0;
        rd_pass_r <= 1'b1;
      end else if (!(rd_pass_r && (rd_addr_r == ws_r))) begin
        rd_addr_r <= rd_addr_r + ADDR_W'(1);
      end
    end
    chk_addr_r <= rd_addr_r;
    chk_pass_r <= rd_pass_r;
    if (accept && bad_req) begin
      out_slot_r   <= '0;
      out_status_r <= STAT_BAD;
    end else if (res_grant) begin
      out_slot_r   <= CNT_W'(hit_idx) + CNT_W'(1);
      out_status_r <= (!chk_pass_r && (CNT_W'(hit_idx) == w_r)) ? STAT_EXACT : STAT_OTHER;
    end else if (res_full) begin
      out_slot_r   <= '0;
      out_status_r <= STAT_FULL;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_granted_slot = out_slot_r;
  assign out_status       = out_status_r;

endmodule

`default_nettype wire

[rtl/core/cnfsa_checker.sv]
// Port-level assertions for the circular next-free-slot allocator, bound to the top level.
`default_nettype none

module cnfsa_checker
  import cnfsa_pkg::*;
(
  input wire logic             clk,
  input wire logic             rst_n,
  input wire logic             start,
  input wire logic             busy,
  input wire logic             out_valid,
  input wire logic [CNT_W-1:0] out_granted_slot,
  input wire logic [1:0]       out_status
);

  // A slot number comes back exactly when a slot was granted.
  a_grant_slot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (((out_status == STAT_EXACT) || (out_status == STAT_OTHER))
                   == (out_granted_slot != '0)))
    else $error("granted slot does not match status");

  // An accepted request either starts a search or is answered at once.
  a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted request neither searched nor answered");

  // A result only follows a transfer or a search in progress.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n)) |-> ($past(busy) || $past(start)))
    else $error("result without a request");

  // A search that ends in a result always frees the input side in the same step.
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && $past(rst_n) && $past(busy)) |-> !busy)
    else $error("busy held after result");

endmodule

bind circular_next_free_slot_allocator cnfsa_checker u_cnfsa_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .out_valid        (out_valid),
  .out_granted_slot (out_granted_slot),
  .out_status       (out_status)
);

`default_nettype wire

[bench/tb_circular_next_free_slot_allocator.sv]
// Self-checking testbench for the circular next-free-slot allocator.
`timescale 1ns / 100ps
`default_nettype none

module tb_circular_next_free_slot_allocator;
  import cnfsa_pkg::*;

  localparam int NUM_SLOTS = NUM_SLOTS_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 40;

  typedef struct packed {
    logic [CNT_W-1:0] granted;
    status_t          status;
  } grant_t;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic [CNT_W-1:0] in_wanted_slot = '0;
  logic             cfg_we = 1'b0;
  logic [CNT_W-1:0] cfg_wdata = '0;
  logic             busy;
  logic             out_valid;
  logic [CNT_W-1:0] out_granted_slot;
  logic [1:0]       out_status;

  // Mirror of the block: occupancy per slot and the slot count register.
  logic             slot_taken [1:NUM_SLOTS];
  logic [CNT_W-1:0] slot_count = SLOTS_RST;
  logic [CNT_W-1:0] last_grant = '0;
  grant_t           pending_grants [$];
  int               error_count = 0;
  int               cycle_count = 0;

  circular_next_free_slot_allocator #(
    .NUM_SLOTS(NUM_SLOTS)
  ) u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_wanted_slot  (in_wanted_slot),
    .out_valid       (out_valid),
    .out_granted_slot(out_granted_slot),
    .out_status      (out_status),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    for (int s = 1; s <= NUM_SLOTS; s++) slot_taken[s] = 1'b0;
  end

  function automatic int active_slots();
    return (slot_count > NUM_SLOTS) ? NUM_SLOTS : int'(slot_count);
  endfunction

  // Works out the grant for one request and marks the granted slot taken.
  function automatic grant_t allocate_slot(input logic [CNT_W-1:0] wanted);
    grant_t g;
    int     count;
    int     slot;
    logic   found;
    count = active_slots();
    slot = int'(wanted);
    found = 1'b0;
    g.granted = '0;
    if (slot < 1 || slot > count) begin
      g.status = STAT_BAD;
    end else if (!slot_taken[slot]) begin
      slot_taken[slot] = 1'b1;
      g.granted = wanted;
      g.status = STAT_EXACT;
    end else begin
      g.status = STAT_FULL;
      for (int i = 1; i < count && !found; i++) begin
        slot = (slot >= count) ? 1 : slot + 1;
        if (!slot_taken[slot]) begin
          slot_taken[slot] = 1'b1;
          g.granted = CNT_W'(slot);
          g.status = STAT_OTHER;
          found = 1'b1;
        end
      end
    end
    return g;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  // Results are checked against the oldest prediction; accepted requests and
  // register writes then update the mirror, in the order the block sees them.
  always @(posedge clk) begin
    grant_t exp_g;
    grant_t new_g;
    cycle_count++;
    if (rst_n) begin
      if (out_valid) begin
        if (pending_grants.size() == 0) begin
          flag_mismatch($sformatf("unexpected result slot %0d status %0d",
                                  out_granted_slot, out_status));
        end else begin
          exp_g = pending_grants.pop_front();
          if (out_granted_slot !== exp_g.granted)
            flag_mismatch($sformatf("granted slot %0d, expected %0d",
                                    out_granted_slot, exp_g.granted));
          if (out_status !== exp_g.status)
            flag_mismatch($sformatf("status %0d, expected %0d (slot %0d)",
                                    out_status, exp_g.status, exp_g.granted));
        end
      end
      if (start && busy === 1'b0) begin
        new_g = allocate_slot(in_wanted_slot);
        pending_grants.push_back(new_g);
        if (new_g.granted != 0) last_grant = new_g.granted;
      end
      if (cfg_we) slot_count = cfg_wdata;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Holds start high until busy is seen low; start is left high so that a following
  // request can go out with no idle gap in between.
  task automatic send_request(input logic [CNT_W-1:0] wanted);
    start <= 1'b1;
    in_wanted_slot <= wanted;
    @(posedge clk);
    while (busy !== 1'b0) @(posedge clk);
  endtask

  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_grants.size() != 0 || busy !== 1'b0) @(posedge clk);
  endtask

  task automatic set_slot_count(input logic [CNT_W-1:0] count);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= count;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Count left at its reset value: edges of the table, wrap-around and bad requests.
  task automatic test_reset_count();
    send_request(11'd1);
    send_request(11'd1024);
    send_request(11'd1);
    send_request(11'd1024);
    send_request(11'd0);
    send_request(11'd1025);
    send_request(11'd2047);
    send_request(11'd512);
  endtask

  // A single-slot table whose only slot is already taken.
  task automatic test_single_slot();
    set_slot_count(11'd1);
    send_request(11'd1);
    send_request(11'd2);
  endtask

  // Fill a small table completely, wrapping past its top.
  task automatic test_fill_small();
    set_slot_count(11'd6);
    send_request(11'd5);
    send_request(11'd5);
    send_request(11'd5);
    send_request(11'd6);
    send_request(11'd1);
  endtask

  task automatic test_zero_count();
    set_slot_count(11'd0);
    send_request(11'd1);
    send_request(11'd0);
  endtask

  // Counts above the table size saturate; shrinking keeps occupancy of upper slots.
  task automatic test_count_limits();
    set_slot_count(11'd2047);
    send_request(11'd1024);
    send_request(11'd1025);
    send_request(11'd2047);
    set_slot_count(11'd3);
    send_request(11'd3);
    set_slot_count(11'd1024);
    send_request(11'd5);
  endtask

  function automatic logic [CNT_W-1:0] pick_count();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return CNT_W'(1);
      2:       return CNT_W'($urandom_range(2, 16));
      3:       return CNT_W'(1024);
      4:       return CNT_W'($urandom_range(1025, 2047));
      5:       return CNT_W'(2047);
      default: return CNT_W'($urandom_range(17, 1023));
    endcase
  endfunction

  // Mostly in-range requests, many aimed at recently granted slots to force
  // scans, with out-of-range and fully random values mixed in.
  function automatic logic [CNT_W-1:0] pick_wanted();
    int count;
    int r;
    count = active_slots();
    r = $urandom_range(0, 99);
    if (r < 25 && last_grant != 0) return last_grant;
    if (r < 80) return CNT_W'($urandom_range(1, (count < 1) ? 1 : count));
    if (r < 88) return CNT_W'($urandom_range(count + 1, 2047));
    if (r < 93) return '0;
    return CNT_W'($urandom_range(0, 2047));
  endfunction

  // Random phases, each with its own slot count, sent in bursts; every fourth phase has no gaps between bursts.
  task automatic test_random_phases(input int phases, input int per_phase);
    int burst_left;
    int gap;
    logic calm;
    for (int p = 0; p < phases; p++) begin
      set_slot_count(pick_count());
      calm = (p % 4 == 3);
      burst_left = 0;
      for (int n = 0; n < per_phase; n++) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
          end
        end
        send_request(pick_wanted());
        burst_left--;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_count();
    test_single_slot();
    test_fill_small();
    test_zero_count();
    test_count_limits();
    test_random_phases(13, 50);
    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

[circular_next_free_slot_allocator.f]
rtl/core/cnfsa_pkg.sv
rtl/core/cnfsa_find.sv
rtl/core/circular_next_free_slot_allocator.sv
rtl/core/cnfsa_checker.sv
bench/tb_circular_next_free_slot_allocator.sv
